[rtl/vector_rotate_polar_unit_macros.svh]
// Assertion macros for the vector rotate and polar unit.
`ifndef VECTOR_ROTATE_POLAR_UNIT_MACROS_SVH
`define VECTOR_ROTATE_POLAR_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define VRPU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define VRPU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/vrpu_pkg.sv]
// Shared constants, types and the arctangent table of the vector rotate and polar unit.
`default_nettype none

package vrpu_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRAC_BITS_DEF     = 8;

  localparam int ANG_SH       = 13;        // angle fraction bits below 1/128 degree
  localparam int DEG180       = 23040;     // 180 degrees in 1/128 degree
  localparam int INV_GAIN_Q30 = 652032874; // 2^30 / CORDIC gain
  localparam int XY_MAX       = 8388607;
  localparam int XY_MIN       = -8388608;
  localparam int MAG_MAX      = 33554431;

  localparam logic [1:0] MODE_ROT     = 2'd0;
  localparam logic [1:0] MODE_ROT_OFS = 2'd1;
  localparam logic [1:0] MODE_POLAR   = 2'd2;
  localparam logic [1:0] MODE_DIST    = 2'd3;

  // Sideband that travels with each word down the pipeline.
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [23:0] bx;
    logic signed [23:0] by;
    logic               zero_y;  // polar input with zero y: exact result
    logic               x_neg;   // polar input x below zero
    logic               fold;    // rotation angle folded by 180 degrees
    logic [24:0]        mag_sp;  // exact length for the zero-y case
  } side_t;

  // atan(2^-i) in 1/(128*8192) degree, rounded to nearest.
  function automatic int atan_val(input int i);
    int v;
    case (i)
      0:       v = 47185920;
      1:       v = 27855475;
      2:       v = 14718068;
      3:       v = 7471121;
      4:       v = 3750058;
      5:       v = 1876857;
      6:       v = 938658;
      7:       v = 469357;
      8:       v = 234682;
      9:       v = 117342;
      10:      v = 58671;
      11:      v = 29335;
      12:      v = 14668;
      13:      v = 7334;
      14:      v = 3667;
      15:      v = 1833;
      16:      v = 917;
      17:      v = 458;
      18:      v = 229;
      19:      v = 115;
      20:      v = 57;
      21:      v = 29;
      22:      v = 14;
      23:      v = 7;
      default: v = 0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/vector_rotate_polar_unit.sv]
// Vector rotate and polar unit: pipelined CORDIC with rotation and vectoring modes.
// A word passes stages 1, 2 and 3, the CORDIC entry stage and chain, then E1 and E2 to the result strobe.
// Throughput: one word per cycle; busy stays low, since every stage advances each cycle.
// Depth is set by the CORDIC chain, one micro-rotation per register stage.
// Reset (synchronous, rst_n low) clears the valid bits only; no result is pending after it.
// The receiver cannot stall: out_valid marks each result for exactly one cycle.
`default_nettype none

`include "vector_rotate_polar_unit_macros.svh"

module vector_rotate_polar_unit #(
  parameter int CORDIC_STAGES = vrpu_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = vrpu_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic signed [23:0] in_ax,
  input  logic signed [23:0] in_ay,
  input  logic signed [23:0] in_bx,
  input  logic signed [23:0] in_by,
  input  logic signed [16:0] in_turn_deg,
  output logic               out_valid,
  output logic signed [23:0] out_rx,
  output logic signed [23:0] out_ry,
  output logic signed [15:0] out_heading_deg,
  output logic [24:0]        out_magnitude,
  output logic               out_clipped
);

  localparam int W   = FRAC_BITS + 28;       // datapath width with guard bits
  localparam int PW  = 56;                   // prescale product width
  localparam int PSH = 30 - FRAC_BITS;       // prescale shift
  localparam int QW  = W - FRAC_BITS;        // width back in Q15.8
  localparam int ZW  = 17 + vrpu_pkg::ANG_SH;
  localparam int LAT = CORDIC_STAGES + 6;

  localparam logic signed [30:0]   GAIN_S  = 31'(vrpu_pkg::INV_GAIN_Q30);
  localparam logic signed [PW-1:0] PRND    = (PW'(1) << PSH) >> 1;
  localparam logic signed [W-1:0]  XRND    = (W'(1) << FRAC_BITS) >> 1;
  localparam logic signed [17:0]   T180    = 18'(vrpu_pkg::DEG180);
  localparam logic signed [17:0]   T360    = 18'(2 * vrpu_pkg::DEG180);
  localparam logic signed [16:0]   T90     = 17'(vrpu_pkg::DEG180 / 2);
  localparam logic signed [16:0]   T180S   = 17'(vrpu_pkg::DEG180);
  localparam logic signed [ZW-1:0] Z180    = ZW'(vrpu_pkg::DEG180 * (1 << vrpu_pkg::ANG_SH));
  localparam logic signed [ZW-1:0] Z360    = ZW'(2 * vrpu_pkg::DEG180 * (1 << vrpu_pkg::ANG_SH));
  localparam logic signed [ZW-1:0] ZRND    = ZW'(1 << (vrpu_pkg::ANG_SH - 1));
  localparam logic signed [28:0]   SUM_MAX = 29'(vrpu_pkg::XY_MAX);
  localparam logic signed [28:0]   SUM_MIN = 29'(vrpu_pkg::XY_MIN);
  localparam logic signed [QW-1:0] MAG_LIM = QW'(vrpu_pkg::MAG_MAX);
  localparam logic signed [23:0]   RX_MAX  = 24'(vrpu_pkg::XY_MAX);
  localparam logic signed [23:0]   RX_MIN  = 24'(vrpu_pkg::XY_MIN);
  localparam logic signed [15:0]   HEAD_MAX = 16'(vrpu_pkg::DEG180);
  localparam logic signed [15:0]   HEAD_MIN = -16'(vrpu_pkg::DEG180);

  assign busy = 1'b0;

  // ---------------------------------------------------------------- stage 1
  // Form the vector (A or A minus B) and bring the angle into +/-180.
  logic                  s1_v_r;
  vrpu_pkg::side_t       s1_side_r, s1_side_nxt;
  logic signed [24:0]    s1_vx_r, s1_vy_r, s1_vx_nxt, s1_vy_nxt;
  logic signed [16:0]    s1_turn_r, s1_turn_nxt;
  logic signed [17:0]    turn_ext;
  logic signed [17:0]    turn_red;

  always_comb begin
    s1_side_nxt      = '0;
    s1_side_nxt.mode = in_mode;
    s1_side_nxt.bx   = in_bx;
    s1_side_nxt.by   = in_by;
    if (in_mode == vrpu_pkg::MODE_DIST) begin
      s1_vx_nxt = {in_ax[23], in_ax} - {in_bx[23], in_bx};
      s1_vy_nxt = {in_ay[23], in_ay} - {in_by[23], in_by};
    end else begin
      s1_vx_nxt = {in_ax[23], in_ax};
      s1_vy_nxt = {in_ay[23], in_ay};
    end
    turn_ext = {in_turn_deg[16], in_turn_deg};
    if (turn_ext > T180) begin
      turn_red = turn_ext - T360;
    end else if (turn_ext < -T180) begin
      turn_red = turn_ext + T360;
    end else begin
      turn_red = turn_ext;
    end
    s1_turn_nxt = turn_red[16:0];
  end

  // ---------------------------------------------------------------- stage 2
  // Multiply by the inverse gain; fold the angle into +/-90.
  logic                  s2_v_r;
  vrpu_pkg::side_t       s2_side_r, s2_side_nxt;
  logic signed [PW-1:0]  s2_px_r, s2_py_r, s2_px_nxt, s2_py_nxt;
  logic signed [ZW-1:0]  s2_z_r, s2_z_nxt;
  logic signed [16:0]    turn_fold;

  always_comb begin
    s2_px_nxt          = s1_vx_r * GAIN_S;
    s2_py_nxt          = s1_vy_r * GAIN_S;
    s2_side_nxt        = s1_side_r;
    s2_side_nxt.zero_y = (s1_vy_r == '0);
    s2_side_nxt.x_neg  = s1_vx_r[24];
    s2_side_nxt.mag_sp = s1_vx_r[24] ? 25'(-s1_vx_r) : 25'(s1_vx_r);
    s2_side_nxt.fold   = 1'b0;
    if (s1_turn_r > T90) begin
      turn_fold          = s1_turn_r - T180S;
      s2_side_nxt.fold   = 1'b1;
    end else if (s1_turn_r < -T90) begin
      turn_fold          = s1_turn_r + T180S;
      s2_side_nxt.fold   = 1'b1;
    end else begin
      turn_fold          = s1_turn_r;
    end
    s2_z_nxt = {turn_fold, {vrpu_pkg::ANG_SH{1'b0}}};
  end

  // ---------------------------------------------------------------- stage 3
  // Round the products back to the guarded datapath width.
  logic                  s3_v_r;
  vrpu_pkg::side_t       s3_side_r;
  logic signed [W-1:0]   s3_x_r, s3_y_r;
  logic signed [ZW-1:0]  s3_z_r;
  logic signed [PW-1:0]  px_sum, py_sum, px_sh, py_sh;

  always_comb begin
    px_sum = s2_px_r + PRND;
    py_sum = s2_py_r + PRND;
    px_sh  = px_sum >>> PSH;
    py_sh  = py_sum >>> PSH;
  end

  // ---------------------------------------------------------------- CORDIC
  // Entry stage 0 applies the half-turn pre-rotation; stages 1..N each do one step.
  logic [CORDIC_STAGES:0] c_v_r;
  vrpu_pkg::side_t        c_side_r [0:CORDIC_STAGES];
  logic signed [W-1:0]    c_x_r    [0:CORDIC_STAGES];
  logic signed [W-1:0]    c_y_r    [0:CORDIC_STAGES];
  logic signed [ZW-1:0]   c_z_r    [0:CORDIC_STAGES];
  logic signed [W-1:0]    c0_x_nxt, c0_y_nxt;
  logic signed [ZW-1:0]   c0_z_nxt;
  logic signed [W-1:0]    c_x_nxt  [0:CORDIC_STAGES-1];
  logic signed [W-1:0]    c_y_nxt  [0:CORDIC_STAGES-1];
  logic signed [ZW-1:0]   c_z_nxt  [0:CORDIC_STAGES-1];

  always_comb begin
    c0_x_nxt = s3_x_r;
    c0_y_nxt = s3_y_r;
    c0_z_nxt = s3_z_r;
    if (s3_side_r.mode[1]) begin
      c0_z_nxt = '0;
      if (s3_x_r[W-1]) begin
        c0_x_nxt = -s3_x_r;
        c0_y_nxt = -s3_y_r;
        c0_z_nxt = s3_y_r[W-1] ? -Z180 : Z180;
      end
    end else if (s3_side_r.fold) begin
      c0_x_nxt = -s3_x_r;
      c0_y_nxt = -s3_y_r;
    end
  end

  always_comb begin
    logic                 ccw;
    logic signed [W-1:0]  x_sh;
    logic signed [W-1:0]  y_sh;
    logic signed [ZW-1:0] atan_k;
    for (int k = 0; k < CORDIC_STAGES; k++) begin
      // vectoring drives y toward zero, rotation drives z toward zero
      ccw    = c_side_r[k].mode[1] ? (c_y_r[k][W-1] || (c_y_r[k] == '0))
                                   : !c_z_r[k][ZW-1];
      x_sh   = c_x_r[k] >>> k;
      y_sh   = c_y_r[k] >>> k;
      atan_k = ZW'(vrpu_pkg::atan_val(k));
      if (ccw) begin
        c_x_nxt[k] = c_x_r[k] - y_sh;
        c_y_nxt[k] = c_y_r[k] + x_sh;
        c_z_nxt[k] = c_z_r[k] - atan_k;
      end else begin
        c_x_nxt[k] = c_x_r[k] + y_sh;
        c_y_nxt[k] = c_y_r[k] - x_sh;
        c_z_nxt[k] = c_z_r[k] + atan_k;
      end
    end
  end

  // ---------------------------------------------------------------- stage E1
  // Round x and y back to Q15.8; wrap the heading into (-180, 180].
  logic                  e1_v_r;
  vrpu_pkg::side_t       e1_side_r;
  logic signed [QW-1:0]  e1_x_r, e1_y_r, e1_x_nxt, e1_y_nxt;
  logic signed [ZW-1:0]  e1_z_r, e1_z_nxt;
  logic signed [W-1:0]   xe_sum, ye_sum, xe_sh, ye_sh;

  always_comb begin
    xe_sum   = c_x_r[CORDIC_STAGES] + XRND;
    ye_sum   = c_y_r[CORDIC_STAGES] + XRND;
    xe_sh    = xe_sum >>> FRAC_BITS;
    ye_sh    = ye_sum >>> FRAC_BITS;
    e1_x_nxt = xe_sh[QW-1:0];
    e1_y_nxt = ye_sh[QW-1:0];
    if (c_z_r[CORDIC_STAGES] > Z180) begin
      e1_z_nxt = c_z_r[CORDIC_STAGES] - Z360;
    end else if (c_z_r[CORDIC_STAGES] <= -Z180) begin
      e1_z_nxt = c_z_r[CORDIC_STAGES] + Z360;
    end else begin
      e1_z_nxt = c_z_r[CORDIC_STAGES];
    end
  end

  // ---------------------------------------------------------------- stage E2
  // Add the offset (rotate-with-offset mode) and saturate, or finish heading and length.
  logic                  out_valid_r;
  logic signed [23:0]    out_rx_r, out_ry_r, out_rx_nxt, out_ry_nxt;
  logic signed [15:0]    out_head_r, out_head_nxt;
  logic [24:0]           out_mag_r, out_mag_nxt;
  logic                  out_clip_r, out_clip_nxt;
  logic signed [28:0]    sum_x, sum_y;
  logic signed [ZW-1:0]  z_sum, z_sh;

  always_comb begin
    out_rx_nxt   = '0;
    out_ry_nxt   = '0;
    out_head_nxt = '0;
    out_mag_nxt  = '0;
    out_clip_nxt = 1'b0;
    sum_x        = 29'(e1_x_r);
    sum_y        = 29'(e1_y_r);
    z_sum        = e1_z_r + ZRND;
    z_sh         = z_sum >>> vrpu_pkg::ANG_SH;
    if (!e1_side_r.mode[1]) begin
      if (e1_side_r.mode == vrpu_pkg::MODE_ROT_OFS) begin
        sum_x = 29'(e1_x_r) + 29'(e1_side_r.bx);
        sum_y = 29'(e1_y_r) + 29'(e1_side_r.by);
      end
      if (sum_x > SUM_MAX) begin
        out_rx_nxt = RX_MAX; out_clip_nxt = 1'b1;
      end else if (sum_x < SUM_MIN) begin
        out_rx_nxt = RX_MIN; out_clip_nxt = 1'b1;
      end else begin
        out_rx_nxt = sum_x[23:0];
      end
      if (sum_y > SUM_MAX) begin
        out_ry_nxt = RX_MAX; out_clip_nxt = 1'b1;
      end else if (sum_y < SUM_MIN) begin
        out_ry_nxt = RX_MIN; out_clip_nxt = 1'b1;
      end else begin
        out_ry_nxt = sum_y[23:0];
      end
    end else if (e1_side_r.zero_y) begin
      // exact answer on the x axis
      out_head_nxt = e1_side_r.x_neg ? HEAD_MAX : '0;
      out_mag_nxt  = e1_side_r.mag_sp;
    end else begin
      out_head_nxt = z_sh[15:0];
      if (e1_x_r[QW-1]) begin
        out_mag_nxt = '0;
      end else if (e1_x_r > MAG_LIM) begin
        out_mag_nxt = 25'(vrpu_pkg::MAG_MAX);
      end else begin
        out_mag_nxt = e1_x_r[24:0];
      end
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      c_v_r       <= '0;
      e1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= start && !busy;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      c_v_r       <= {c_v_r[CORDIC_STAGES-1:0], s3_v_r};
      e1_v_r      <= c_v_r[CORDIC_STAGES];
      out_valid_r <= e1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_side_r <= s1_side_nxt;
    s1_vx_r   <= s1_vx_nxt;
    s1_vy_r   <= s1_vy_nxt;
    s1_turn_r <= s1_turn_nxt;
    s2_side_r <= s2_side_nxt;
    s2_px_r   <= s2_px_nxt;
    s2_py_r   <= s2_py_nxt;
    s2_z_r    <= s2_z_nxt;
    s3_side_r <= s2_side_r;
    s3_x_r    <= px_sh[W-1:0];
    s3_y_r    <= py_sh[W-1:0];
    s3_z_r    <= s2_z_r;
    c_side_r[0] <= s3_side_r;
    c_x_r[0]    <= c0_x_nxt;
    c_y_r[0]    <= c0_y_nxt;
    c_z_r[0]    <= c0_z_nxt;
    for (int k = 0; k < CORDIC_STAGES; k++) begin
      c_side_r[k+1] <= c_side_r[k];
      c_x_r[k+1]    <= c_x_nxt[k];
      c_y_r[k+1]    <= c_y_nxt[k];
      c_z_r[k+1]    <= c_z_nxt[k];
    end
    e1_side_r  <= c_side_r[CORDIC_STAGES];
    e1_x_r     <= e1_x_nxt;
    e1_y_r     <= e1_y_nxt;
    e1_z_r     <= e1_z_nxt;
    out_rx_r   <= out_rx_nxt;
    out_ry_r   <= out_ry_nxt;
    out_head_r <= out_head_nxt;
    out_mag_r  <= out_mag_nxt;
    out_clip_r <= out_clip_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_rx          = out_rx_r;
  assign out_ry          = out_ry_r;
  assign out_heading_deg = out_head_r;
  assign out_magnitude   = out_mag_r;
  assign out_clipped     = out_clip_r;

  // ---------------------------------------------------------------- checks
  `VRPU_ASSERT_NXT(a_accept_load, start && !busy, s1_v_r, "accepted word not loaded")
  `VRPU_ASSERT_IMP(a_result_origin, out_valid, $past(start && !busy, LAT), "result without a word")
  `VRPU_ASSERT_IMP(a_polar_excl, out_valid && (out_magnitude != '0 || out_heading_deg != '0), out_rx == '0 && out_ry == '0 && !out_clipped, "polar result carries coordinates")
  `VRPU_ASSERT_IMP(a_clip_rail, out_valid && out_clipped, out_rx == RX_MAX || out_rx == RX_MIN || out_ry == RX_MAX || out_ry == RX_MIN, "clip flag without a rail value")
  `VRPU_ASSERT_IMP(a_head_range, out_valid, out_heading_deg >= HEAD_MIN && out_heading_deg <= HEAD_MAX, "heading out of range")

endmodule

`default_nettype wire
